### rtl/core/lfu_pkg.sv
package lfu_pkg;

  // controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // request kinds
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // field widths fixed by the interface
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int STAMP_W = 32;
  localparam int CAP_W = 5;

  // capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

### rtl/core/lfu_ram.sv
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/lfu_cache_engine_unit.sv
// LFU key-value cache, least-recently-used among entries of equal count.
//
// Requests enter on the in_ channel (in_valid / in_stall): in_op selects get
// or put, in_key is the key, in_value the value for a put. Each request gives
// exactly one result on the out_ channel (out_valid / out_stall): hit flag,
// the value read on a get hit, and the key of an entry evicted by a put.
// The cfg_ channel writes capacity_in_use (cfg_valid / cfg_ready, cfg_data);
// write it only while no request is in flight.
//
// Entries live in one synchronous RAM, valid bits in flops. Each request
// walks the RAM one entry per cycle to find the key, the free slot and the
// victim, then writes the touched entry back. The next request is taken only
// once the result of the last one is registered, so the entry walk through
// the single RAM read port sets how often requests can be taken.
//
// Reset (rst_n low, synchronous) empties the cache, sets capacity to 16 and
// clears the stamp counter. While out_stall holds a result, one more request
// can still be taken and walked; its write-back waits for the output slot.
module lfu_cache_engine_unit #(
  parameter int CAPACITY    = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_op,
  input  logic signed [lfu_pkg::KEY_W-1:0]   in_key,
  input  logic signed [lfu_pkg::VAL_W-1:0]   in_value,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_hit,
  output logic signed [lfu_pkg::VAL_W-1:0]   out_read_value,
  output logic                               out_evicted,
  output logic signed [lfu_pkg::KEY_W-1:0]   out_evicted_key,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lfu_pkg::CAP_W-1:0]          cfg_data
);

  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int UW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (UW > lfu_pkg::CAP_W) ? UW : lfu_pkg::CAP_W;
  localparam int KW   = lfu_pkg::KEY_W;
  localparam int VW   = lfu_pkg::VAL_W;
  localparam int SW   = lfu_pkg::STAMP_W;
  localparam int DW   = KW + VW + COUNT_WIDTH + SW;
  // entry layout: key | value | count | stamp
  localparam int S_LO = 0;
  localparam int C_LO = SW;
  localparam int V_LO = SW + COUNT_WIDTH;
  localparam int K_LO = SW + COUNT_WIDTH + VW;

  lfu_pkg::state_t state_r;

  logic [lfu_pkg::CAP_W-1:0] cap_r;
  logic [CAPACITY-1:0]       valid_r;
  logic [SW-1:0]             stamp_r;

  // latched request
  logic          req_op_r;
  logic [KW-1:0] req_key_r;
  logic [VW-1:0] req_value_r;

  // walk state
  logic [IW:0]   issue_r;
  logic          chk_v_r;
  logic [IW-1:0] chk_idx_r;
  logic [UW-1:0] used_r;
  logic                   found_r;
  logic [IW-1:0]          found_idx_r;
  logic [VW-1:0]          found_val_r;
  logic [COUNT_WIDTH-1:0] found_cnt_r;
  logic          free_any_r;
  logic [IW-1:0] free_idx_r;
  logic                   vic_any_r;
  logic [IW-1:0]          vic_idx_r;
  logic [COUNT_WIDTH-1:0] vic_cnt_r;
  logic [SW-1:0]          vic_age_r;
  logic [KW-1:0]          vic_key_r;

  // output register
  logic          out_valid_r;
  logic          out_hit_r;
  logic [VW-1:0] out_rd_r;
  logic          out_ev_r;
  logic [KW-1:0] out_evk_r;

  // ram ports
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [DW-1:0] ram_rdata;

  logic                   in_xfer;
  logic                   issue_now;
  logic                   last_chk;
  logic [KW-1:0]          rd_key;
  logic [VW-1:0]          rd_val;
  logic [COUNT_WIDTH-1:0] rd_cnt;
  logic [SW-1:0]          rd_age;
  logic                   rd_valid;
  logic                   vic_better;
  logic                   done_go;
  logic                   is_put;
  logic                   need_evict;
  logic [COUNT_WIDTH-1:0] cnt_sat;
  logic                   wr_en;
  logic                   set_valid;
  logic [IW-1:0]          wr_idx;
  logic [VW-1:0]          wr_val;
  logic [COUNT_WIDTH-1:0] wr_cnt;
  logic                   do_evict;

  assign in_stall  = (state_r != lfu_pkg::ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = (state_r == lfu_pkg::ST_IDLE);

  assign issue_now = (state_r == lfu_pkg::ST_SCAN) && (issue_r < (IW+1)'(CAPACITY));
  assign last_chk  = chk_v_r && (chk_idx_r == IW'(CAPACITY - 1));

  // entry store
  lfu_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  // fields of the entry under inspection
  assign rd_key   = ram_rdata[K_LO +: KW];
  assign rd_val   = ram_rdata[V_LO +: VW];
  assign rd_cnt   = ram_rdata[C_LO +: COUNT_WIDTH];
  assign rd_age   = stamp_r - ram_rdata[S_LO +: SW];
  assign rd_valid = valid_r[chk_idx_r];

  // lower count wins, equal count goes to the older stamp
  assign vic_better = !vic_any_r || (rd_cnt < vic_cnt_r) ||
                      ((rd_cnt == vic_cnt_r) && (rd_age > vic_age_r));

  // write-back decision
  assign done_go    = (state_r == lfu_pkg::ST_DONE) && (!out_valid_r || !out_stall);
  assign is_put     = (req_op_r == lfu_pkg::OP_PUT);
  assign need_evict = (CMPW'(used_r) >= CMPW'(cap_r)) || !free_any_r;
  assign cnt_sat    = (&found_cnt_r) ? found_cnt_r : found_cnt_r + COUNT_WIDTH'(1);

  always_comb begin
    wr_en     = 1'b0;
    set_valid = 1'b0;
    do_evict  = 1'b0;
    wr_idx    = found_idx_r;
    wr_val    = found_val_r;
    wr_cnt    = cnt_sat;
    if (found_r) begin
      if (!is_put) begin
        wr_en = 1'b1;
      end else if (cap_r != '0) begin
        wr_en  = 1'b1;
        wr_val = req_value_r;
      end
    end else if (is_put && (cap_r != '0)) begin
      wr_en     = 1'b1;
      set_valid = 1'b1;
      wr_val    = req_value_r;
      wr_cnt    = COUNT_WIDTH'(1);
      if (need_evict && vic_any_r) begin
        do_evict = 1'b1;
        wr_idx   = vic_idx_r;
      end else begin
        wr_idx = free_idx_r;
      end
    end
  end

  assign ram_we    = done_go && wr_en;
  assign ram_waddr = wr_idx;
  assign ram_wdata = {req_key_r, wr_val, wr_cnt, stamp_r};

  // controller
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfu_pkg::ST_IDLE;
    end else begin
      unique case (state_r)
        lfu_pkg::ST_IDLE: if (in_xfer) state_r <= lfu_pkg::ST_SCAN;
        lfu_pkg::ST_SCAN: if (last_chk) state_r <= lfu_pkg::ST_DONE;
        lfu_pkg::ST_DONE: if (done_go) state_r <= lfu_pkg::ST_IDLE;
        default:          state_r <= lfu_pkg::ST_IDLE;
      endcase
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lfu_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // valid bits and stamp counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      stamp_r <= '0;
    end else if (ram_we) begin
      stamp_r <= stamp_r + SW'(1);
      if (set_valid) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_op_r    <= in_op;
      req_key_r   <= in_key;
      req_value_r <= in_value;
    end
  end

  // entry walk: issue one read a cycle, inspect it the next
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r    <= '0;
      chk_v_r    <= 1'b0;
      used_r     <= '0;
      found_r    <= 1'b0;
      free_any_r <= 1'b0;
      vic_any_r  <= 1'b0;
    end else if (in_xfer) begin
      issue_r    <= '0;
      chk_v_r    <= 1'b0;
      used_r     <= '0;
      found_r    <= 1'b0;
      free_any_r <= 1'b0;
      vic_any_r  <= 1'b0;
    end else begin
      chk_v_r <= issue_now;
      if (issue_now) begin
        issue_r <= issue_r + (IW+1)'(1);
      end
      if (chk_v_r) begin
        if (rd_valid) begin
          used_r <= used_r + UW'(1);
          if (!found_r && (rd_key == req_key_r)) begin
            found_r <= 1'b1;
          end
          if (vic_better) begin
            vic_any_r <= 1'b1;
          end
        end else if (!free_any_r) begin
          free_any_r <= 1'b1;
        end
      end
    end
  end

  // walk payload
  always_ff @(posedge clk) begin
    if (issue_now) begin
      chk_idx_r <= issue_r[IW-1:0];
    end
    if (chk_v_r) begin
      if (rd_valid) begin
        if (!found_r && (rd_key == req_key_r)) begin
          found_idx_r <= chk_idx_r;
          found_val_r <= rd_val;
          found_cnt_r <= rd_cnt;
        end
        if (vic_better) begin
          vic_idx_r <= chk_idx_r;
          vic_cnt_r <= rd_cnt;
          vic_age_r <= rd_age;
          vic_key_r <= rd_key;
        end
      end else if (!free_any_r) begin
        free_idx_r <= chk_idx_r;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_hit_r <= found_r;
      out_rd_r  <= (found_r && !is_put) ? found_val_r : '0;
      out_ev_r  <= do_evict;
      out_evk_r <= do_evict ? vic_key_r : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_rd_r;
  assign out_evicted     = out_ev_r;
  assign out_evicted_key = out_evk_r;

  // checks
  a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> !out_hit)
    else $error("eviction reported on a hit");

  a_read_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_read_value != '0)) |-> out_hit)
    else $error("nonzero read value without a hit");

  a_write_in_done: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == lfu_pkg::ST_DONE) && !chk_v_r)
    else $error("entry write outside write-back");

  a_stamp_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != lfu_pkg::ST_DONE) |=> $stable(stamp_r))
    else $error("stamp moved without an entry write");

  a_xfer_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == lfu_pkg::ST_SCAN) && (issue_r == '0))
    else $error("walk did not start after request transfer");

endmodule
